// ===== hdl/sbrp_pkg.sv =====
`default_nettype none

package sbrp_pkg;

  // header layout
  localparam logic [4:0]  HDR_LEN       = 5'd20;
  localparam logic [4:0]  TYPE_END      = 5'd2;
  localparam logic [4:0]  LEN_END       = 5'd4;
  localparam logic [4:0]  COOKIE_END    = 5'd8;
  localparam logic [4:0]  TXID_LAST_POS = 5'd19;

  // both message type bytes of a binding success response
  localparam logic [7:0]  MSG_TYPE_BYTE = 8'h01;
  localparam logic [31:0] COOKIE        = 32'h2112A442;
  localparam logic [15:0] COOKIE_HI     = 16'h2112;

  // attribute codes
  localparam logic [15:0] KIND_MAPPED   = 16'h0001;
  localparam logic [15:0] KIND_XOR      = 16'h0020;
  localparam logic [15:0] KIND_XOR2     = 16'h8020;
  localparam logic [7:0]  FAMILY_V4     = 8'h01;
  localparam logic [15:0] MIN_ADDR_LEN  = 16'd8;

  // configuration port
  localparam int          CFG_ADDR_W    = 4;
  localparam int          CFG_DATA_W    = 64;
  localparam logic        REG_TXID_UPPER = 1'b0;
  localparam logic        REG_TXID_LOWER = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_TYPE   = 3'd2,
    ST_COOKIE = 3'd3,
    ST_TXID   = 3'd4,
    ST_NOADDR = 3'd5
  } status_t;

  // header checker view of the current byte
  typedef struct packed {
    logic    done;
    logic    done_next;
    status_t status_next;
  } hdr_info_t;

  // attribute walker view of the current byte
  typedef struct packed {
    logic        found;
    logic [31:0] ip;
    logic [15:0] port;
  } addr_info_t;

endpackage

`default_nettype wire

// ===== hdl/stun_binding_response_parser_unit.sv =====
// STUN binding response parser: takes a received datagram one byte per transfer, with
// last_byte set on its final byte, checks the 20-byte header (type, magic cookie and the
// 96-bit transaction ID set in txid_upper at address 0 and txid_lower at address 8),
// walks the padded attributes and, on the final byte only, returns one result transfer
// with success, status, and the IPv4 address and port of the last complete MAPPED-ADDRESS
// or XOR-MAPPED-ADDRESS attribute (address and port are zero unless success). One byte is
// taken every clock while no result is held; a result passes from its last byte through
// an input register and a combinational parse step into the result register. While a
// result is held by out_stall the whole path holds. The transaction ID registers may be
// changed only between datagrams.
`default_nettype none

module stun_binding_response_parser_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // byte input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        packet_byte,
  input  wire logic                              last_byte,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   success,
  output logic [2:0]                             status,
  output logic [31:0]                            ip_address,
  output logic [15:0]                            mapped_port,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sbrp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [sbrp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sbrp_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  // expected transaction id
  logic [31:0] txid_upper;
  logic [63:0] txid_lower;

  // input register stage
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  // pipeline control
  logic        hold;
  logic        step;
  logic        clear;
  logic        attr_step;

  sbrp_pkg::hdr_info_t  hdr;
  sbrp_pkg::addr_info_t addr;
  sbrp_pkg::status_t    res_status;

  // ---------------------------------------------------------------------------
  // configuration port, register picked by address bit 3
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      txid_upper <= '0;
      txid_lower <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        sbrp_pkg::REG_TXID_UPPER: txid_upper <= pwdata[31:0];
        default:                  txid_lower <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      sbrp_pkg::REG_TXID_UPPER: prdata = {32'h0, txid_upper};
      default:                  prdata = txid_lower;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: everything moves unless a result waits on a stalled output
  // ---------------------------------------------------------------------------
  assign hold     = out_valid && out_stall;
  assign in_stall = hold;
  assign step     = s1_valid && !hold;
  // per-datagram state returns to reset after the final byte
  assign clear    = step && s1_last;
  // bytes after the header go to the attribute walker
  assign attr_step = step && hdr.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_byte <= packet_byte;
      s1_last <= last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // parse units
  // ---------------------------------------------------------------------------
  sbrp_header u_header (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .clear      (clear),
    .data_byte  (s1_byte),
    .txid_upper (txid_upper),
    .txid_lower (txid_lower),
    .info       (hdr)
  );

  sbrp_attr u_attr (
    .clk       (clk),
    .rst       (rst),
    .step      (attr_step),
    .clear     (clear),
    .data_byte (s1_byte),
    .info      (addr)
  );

  // ---------------------------------------------------------------------------
  // result: too short first, then the first header error, then missing address
  // ---------------------------------------------------------------------------
  always_comb begin
    priority if (!hdr.done_next) begin
      res_status = sbrp_pkg::ST_SHORT;
    end else if (hdr.status_next != sbrp_pkg::ST_OK) begin
      res_status = hdr.status_next;
    end else if (!addr.found) begin
      res_status = sbrp_pkg::ST_NOADDR;
    end else begin
      res_status = sbrp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= clear;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      success     <= (res_status == sbrp_pkg::ST_OK);
      status      <= res_status;
      ip_address  <= (res_status == sbrp_pkg::ST_OK) ? addr.ip : 32'h0;
      mapped_port <= (res_status == sbrp_pkg::ST_OK) ? addr.port : 16'h0;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_success_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (success == (status == sbrp_pkg::ST_OK)))
    else $error("success flag disagrees with status");

  a_failure_zero_address: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (ip_address == 32'h0 && mapped_port == 16'h0))
    else $error("address given on a failed result");

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_result_only_after_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(s1_valid && s1_last))
    else $error("result without a final byte");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== hdl/sbrp_header.sv =====
`default_nettype none

module sbrp_header (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               clear,
  input  wire logic [7:0]         data_byte,
  input  wire logic [31:0]        txid_upper,
  input  wire logic [63:0]        txid_lower,
  output sbrp_pkg::hdr_info_t     info
);

  logic [4:0]        pos;
  logic [4:0]        pos_next;
  sbrp_pkg::status_t status;
  sbrp_pkg::status_t status_next;
  sbrp_pkg::status_t code;
  logic [7:0]        want;
  logic [95:0]       txid_all;
  logic [3:0]        txid_rev;
  logic [6:0]        txid_shift;

  assign txid_all   = {txid_upper, txid_lower};
  assign txid_rev   = 4'(sbrp_pkg::TXID_LAST_POS - pos);
  assign txid_shift = {txid_rev, 3'b000};

  // expected byte and the error it raises for the current position
  always_comb begin
    want = 8'h00;
    code = sbrp_pkg::ST_OK;
    if (pos < sbrp_pkg::TYPE_END) begin
      code = sbrp_pkg::ST_TYPE;
      want = sbrp_pkg::MSG_TYPE_BYTE;
    end else if (pos < sbrp_pkg::LEN_END) begin
      code = sbrp_pkg::ST_OK;
    end else if (pos < sbrp_pkg::COOKIE_END) begin
      code = sbrp_pkg::ST_COOKIE;
      want = 8'(sbrp_pkg::COOKIE >> {~pos[1:0], 3'b000});
    end else begin
      code = sbrp_pkg::ST_TXID;
      want = 8'(txid_all >> txid_shift);
    end
  end

  // first mismatch sticks
  always_comb begin
    pos_next    = pos;
    status_next = status;
    if (pos != sbrp_pkg::HDR_LEN) begin
      pos_next = pos + 5'd1;
      if (status == sbrp_pkg::ST_OK && code != sbrp_pkg::ST_OK && data_byte != want) begin
        status_next = code;
      end
    end
  end

  assign info.done        = (pos == sbrp_pkg::HDR_LEN);
  assign info.done_next   = (pos_next == sbrp_pkg::HDR_LEN);
  assign info.status_next = status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      status <= sbrp_pkg::ST_OK;
    end else if (clear) begin
      pos    <= '0;
      status <= sbrp_pkg::ST_OK;
    end else if (step) begin
      pos    <= pos_next;
      status <= status_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sbrp_attr.sv =====
`default_nettype none

module sbrp_attr (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               clear,
  input  wire logic [7:0]         data_byte,
  output sbrp_pkg::addr_info_t    info
);

  // control
  logic [1:0]  hdr_idx;
  logic [1:0]  hdr_idx_next;
  logic        in_value;
  logic        in_value_next;
  logic [16:0] vidx;
  logic [16:0] vidx_next;
  logic [16:0] vidx_inc;
  logic        found;
  logic        found_next;
  // payload
  logic [15:0] kind;
  logic [15:0] kind_next;
  logic [15:0] len;
  logic [15:0] len_next;
  logic [7:0]  family;
  logic [7:0]  family_next;
  logic [15:0] port;
  logic [15:0] port_next;
  logic [31:0] ip;
  logic [31:0] ip_next;
  logic [31:0] found_ip;
  logic [31:0] found_ip_next;
  logic [15:0] found_port;
  logic [15:0] found_port_next;
  logic [16:0] pad_len;
  logic        is_xor;
  logic        is_plain;

  assign pad_len  = (17'(len) + 17'd3) & 17'h1FFFC;
  assign vidx_inc = vidx + 17'd1;
  assign is_xor   = (kind == sbrp_pkg::KIND_XOR) || (kind == sbrp_pkg::KIND_XOR2);
  assign is_plain = (kind == sbrp_pkg::KIND_MAPPED);

  always_comb begin
    hdr_idx_next    = hdr_idx;
    in_value_next   = in_value;
    vidx_next       = vidx;
    found_next      = found;
    kind_next       = kind;
    len_next        = len;
    family_next     = family;
    port_next       = port;
    ip_next         = ip;
    found_ip_next   = found_ip;
    found_port_next = found_port;
    if (!in_value) begin
      // 4-byte attribute header: type then length, big endian
      unique case (hdr_idx)
        2'd0:    kind_next = {data_byte, kind[7:0]};
        2'd1:    kind_next = {kind[15:8], data_byte};
        2'd2:    len_next  = {data_byte, len[7:0]};
        default: len_next  = {len[15:8], data_byte};
      endcase
      if (hdr_idx != 2'd3) begin
        hdr_idx_next = hdr_idx + 2'd1;
      end else begin
        hdr_idx_next  = 2'd0;
        vidx_next     = '0;
        family_next   = '0;
        port_next     = '0;
        ip_next       = '0;
        // empty attribute ends with its header
        in_value_next = (len_next != 16'd0);
      end
    end else begin
      if (vidx == 17'd1) begin
        family_next = data_byte;
      end else if (vidx == 17'd2 || vidx == 17'd3) begin
        port_next = {port[7:0], data_byte};
      end else if (vidx >= 17'd4 && vidx <= 17'd7) begin
        ip_next = {ip[23:0], data_byte};
      end
      vidx_next = vidx_inc;
      // end of value plus padding
      if (vidx_inc >= pad_len) begin
        if ((is_xor || is_plain) && len >= sbrp_pkg::MIN_ADDR_LEN
            && family_next == sbrp_pkg::FAMILY_V4) begin
          found_next      = 1'b1;
          found_port_next = is_xor ? (port_next ^ sbrp_pkg::COOKIE_HI) : port_next;
          found_ip_next   = is_xor ? (ip_next ^ sbrp_pkg::COOKIE) : ip_next;
        end
        in_value_next = 1'b0;
        hdr_idx_next  = 2'd0;
        vidx_next     = '0;
      end
    end
  end

  // gated view: outside the attribute area the stored address stands
  assign info.found = step ? found_next      : found;
  assign info.ip    = step ? found_ip_next   : found_ip;
  assign info.port  = step ? found_port_next : found_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx  <= '0;
      in_value <= 1'b0;
      vidx     <= '0;
      found    <= 1'b0;
    end else if (clear) begin
      hdr_idx  <= '0;
      in_value <= 1'b0;
      vidx     <= '0;
      found    <= 1'b0;
    end else if (step) begin
      hdr_idx  <= hdr_idx_next;
      in_value <= in_value_next;
      vidx     <= vidx_next;
      found    <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind       <= kind_next;
      len        <= len_next;
      family     <= family_next;
      port       <= port_next;
      ip         <= ip_next;
      found_ip   <= found_ip_next;
      found_port <= found_port_next;
    end
  end

endmodule

`default_nettype wire
